[rtl/rolling_zscore_streamer_top_defines.svh]
// Assertion macros shared by the rolling z-score streamer checkers.
// Expects clk and rst_n to be visible in the scope that uses them.
`ifndef ROLLING_ZSCORE_STREAMER_TOP_DEFINES_SVH
`define ROLLING_ZSCORE_STREAMER_TOP_DEFINES_SVH

// Same-cycle implication, gated off during reset.
`define RZS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, gated off during reset.
`define RZS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/rzs_pkg.sv]
// Shared types and constants for the rolling z-score streamer.
// No dependencies; used by the channel interfaces, the top level and the checker.
package rzs_pkg;

  // Fixed field widths
  localparam int SAMPLE_BITS = 16;
  localparam int Z_W         = 16;
  localparam int ST_W        = 2;
  localparam int WL_W        = 9;
  localparam int SPREAD_W    = 48;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 48;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_FILL = 2'd1;
  localparam logic [ST_W-1:0] ST_FLAT = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPREAD = 1'd1;

  // Reset values
  localparam logic [WL_W-1:0] WL_RESET = 9'd16;

  // Saturation limits of the z-score
  localparam logic signed [Z_W-1:0] Z_MAX = 16'sh7FFF;
  localparam logic signed [Z_W-1:0] Z_MIN = 16'sh8000;

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

[rtl/rzs_if.sv]
// Valid/ready channel interfaces: sample input, z-score result, config write.
// Depends on rzs_pkg for the field widths.
interface rzs_in_if import rzs_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          new_series;

  modport source (output valid, sample, new_series, input ready);
  modport sink   (input valid, sample, new_series, output ready);
endinterface

interface rzs_out_if import rzs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic signed [Z_W-1:0] z_score;
  logic [ST_W-1:0]       status;

  modport source (output valid, z_score, status, input ready);
  modport sink   (input valid, z_score, status, output ready);
endinterface

interface rzs_cfg_if import rzs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/rolling_zscore_streamer_top.sv]
// Rolling z-score streamer. Each accepted sample yields one result:
// z = (W*x - S) / isqrt(W*Q - S*S) in signed Q5.10 (FRAC_BITS fraction bits),
// truncated toward zero and saturated, with status ok, filling or flat.
// A sample passes through 9 setup steps, AD_W/2 square-root steps, a
// saturation check, Z_W-1 divide steps and a hand-off step; a filling
// window goes to the hand-off after the step that forms num, a flat one
// after the spread compare, a saturated score after the saturation check.
// A stalled result holds the sequencer in its hand-off step until
// the output register frees up. The single shared adder runs
// the sum updates, the spread compare, the bit-pair square root and the
// restoring divide one step per cycle. in_ch.ready is high only while idle
// and no register write is offered; cfg_ch.ready is high only while idle.
// The sample history needs no clearing pass: only entries written in the
// current series are ever read. Depends on rzs_pkg and rzs_if.
module rolling_zscore_streamer_top import rzs_pkg::*; #(
  parameter int MAX_WINDOW = 256,
  parameter int FRAC_BITS  = 10
) (
  input  logic       clk,
  input  logic       rst_n,
  rzs_cfg_if.sink    cfg_ch,
  rzs_in_if.sink     in_ch,
  rzs_out_if.source  out_ch
);

  // Derived widths
  localparam int AW       = $clog2(MAX_WINDOW);
  localparam int W_W      = AW + 1;
  localparam int SUM_W    = SAMPLE_BITS + AW;
  localparam int SQ_W     = 2 * SAMPLE_BITS + AW;
  localparam int MUL_W    = SUM_W + 1;
  localparam int NUM_W    = SUM_W + 2;
  localparam int AD_W     = imax(imax(2 * SUM_W + 1, SPREAD_W + 2),
                                 imax(SUM_W + FRAC_BITS + 2, SUM_W + Z_W + 1));
  localparam int ROOT_ITER = AD_W / 2;
  localparam int CNT_W    = $clog2(imax(ROOT_ITER, Z_W) + 1);

  // Sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MX   = 4'd1;   // x*x, S += x
  localparam logic [3:0] S_MO   = 4'd2;   // old*old, Q += x*x
  localparam logic [3:0] S_SO   = 4'd3;   // Q -= old*old
  localparam logic [3:0] S_SU   = 4'd4;   // S -= old
  localparam logic [3:0] S_NM   = 4'd5;   // num = W*x - S, S*S
  localparam logic [3:0] S_SS   = 4'd6;   // D = -S*S
  localparam logic [3:0] S_WL   = 4'd7;   // D += W*Qlo
  localparam logic [3:0] S_WH   = 4'd8;   // D += W*Qhi << SUM_W
  localparam logic [3:0] S_CMP  = 4'd9;   // D vs min_spread
  localparam logic [3:0] S_RT   = 4'd10;  // square root step
  localparam logic [3:0] S_SAT  = 4'd11;  // saturation check
  localparam logic [3:0] S_DV   = 4'd12;  // divide step
  localparam logic [3:0] S_DONE = 4'd13;

  // Control and state registers
  logic [3:0]                    state_r;
  logic [WL_W-1:0]               wl_r;
  logic [SPREAD_W-1:0]           spread_r;
  logic [AW-1:0]                 wr_slot_r;
  logic [W_W-1:0]                fill_r;
  logic signed [SUM_W-1:0]       sum_r;
  logic [SQ_W-1:0]               sq_r;
  logic [CNT_W-1:0]              cnt_r;
  logic                          out_valid_r;

  // Per-item working registers
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic signed [SAMPLE_BITS-1:0] rd_q_r;
  logic [W_W-1:0]                w_r;
  logic                          full_r;
  logic                          ok_r;
  logic signed [NUM_W-1:0]       num_r;
  logic signed [AD_W-1:0]        acc_r;
  logic [AD_W-1:0]               root_r;
  logic [AD_W-1:0]               aux_r;
  logic [Z_W-2:0]                q_r;
  logic signed [2*MUL_W-1:0]     prod_r;
  logic signed [Z_W-1:0]         res_z_r;
  logic [ST_W-1:0]               res_st_r;
  logic signed [Z_W-1:0]         out_z_r;
  logic [ST_W-1:0]               out_st_r;

  // Sample history
  logic signed [SAMPLE_BITS-1:0] hist_mem [MAX_WINDOW];

  // Combinational helpers
  logic                          in_fire;
  logic                          out_fire;
  logic                          cfg_fire;
  logic [W_W-1:0]                w_eff;
  logic                          clr;
  logic [W_W-1:0]                fill_base;
  logic [W_W-1:0]                fill_inc;
  logic                          full;
  logic [W_W-1:0]                slot_diff;
  logic [W_W-1:0]                slot_wrap;
  logic [AW-1:0]                 rd_addr;
  logic [AW-1:0]                 wr_slot_inc;
  logic signed [SAMPLE_BITS-1:0] old_g;
  logic signed [MUL_W-1:0]       mul_a;
  logic signed [MUL_W-1:0]       mul_b;
  logic signed [AD_W-1:0]        add_a;
  logic signed [AD_W-1:0]        add_b;
  logic                          add_sub;
  logic signed [AD_W-1:0]        add_res;
  logic                          add_ge;
  logic                          num_neg;
  logic [NUM_W-1:0]              num_abs;
  logic [Z_W-2:0]                q_fin;
  logic signed [Z_W-1:0]         q_ext;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign cfg_fire = cfg_ch.valid && cfg_ch.ready;

  // Register writes only between items; an offered write holds off the next sample
  assign in_ch.ready    = (state_r == S_IDLE) && !cfg_ch.valid;
  assign cfg_ch.ready   = (state_r == S_IDLE);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.z_score = out_z_r;
  assign out_ch.status  = out_st_r;

  // Effective window: 0 acts as 1, clamp to MAX_WINDOW
  always_comb begin
    if (wl_r == '0) begin
      w_eff = W_W'(1);
    end else if (int'(wl_r) > MAX_WINDOW) begin
      w_eff = W_W'(MAX_WINDOW);
    end else begin
      w_eff = W_W'(wl_r);
    end
  end

  // Series bookkeeping for the item being taken
  assign clr       = in_ch.new_series || (fill_r > w_eff);
  assign fill_base = clr ? '0 : fill_r;
  assign fill_inc  = fill_base + W_W'(1);
  assign full      = (fill_base == w_eff);

  // Oldest slot in the window, modulo MAX_WINDOW
  assign slot_diff = W_W'(wr_slot_r) - w_eff;
  assign slot_wrap = W_W'(wr_slot_r) + W_W'(MAX_WINDOW) - w_eff;
  assign rd_addr   = (W_W'(wr_slot_r) >= w_eff) ? AW'(slot_diff) : AW'(slot_wrap);
  assign wr_slot_inc = (wr_slot_r == AW'(MAX_WINDOW - 1)) ? '0 : wr_slot_r + AW'(1);

  // History memory: one write, one registered read per transfer
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_q_r              <= hist_mem[rd_addr];
      hist_mem[wr_slot_r] <= in_ch.sample;
    end
  end

  assign old_g = full_r ? rd_q_r : '0;

  // Shared multiplier operands, product registered every cycle
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_MX: begin
        mul_a = MUL_W'(x_r);
        mul_b = MUL_W'(x_r);
      end
      S_MO: begin
        mul_a = MUL_W'(old_g);
        mul_b = MUL_W'(old_g);
      end
      S_SO, S_SU: begin
        mul_a = MUL_W'(w_r);
        mul_b = MUL_W'(x_r);
      end
      S_NM: begin
        mul_a = MUL_W'(sum_r);
        mul_b = MUL_W'(sum_r);
      end
      S_SS: begin
        mul_a = MUL_W'(w_r);
        mul_b = MUL_W'(sq_r[SUM_W-1:0]);
      end
      S_WL: begin
        mul_a = MUL_W'(w_r);
        mul_b = MUL_W'(sq_r[SQ_W-1:SUM_W]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // Divide operand helpers
  assign num_neg = num_r[NUM_W-1];
  assign num_abs = num_neg ? NUM_W'(-num_r) : NUM_W'(num_r);

  // Shared adder operand selection
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    unique case (state_r)
      S_MX: begin
        add_a = AD_W'(sum_r);
        add_b = AD_W'(x_r);
      end
      S_MO: begin
        add_a = AD_W'(sq_r);
        add_b = AD_W'(prod_r);
      end
      S_SO: begin
        add_a   = AD_W'(sq_r);
        add_b   = AD_W'(prod_r);
        add_sub = 1'b1;
      end
      S_SU: begin
        add_a   = AD_W'(sum_r);
        add_b   = AD_W'(old_g);
        add_sub = 1'b1;
      end
      S_NM: begin
        add_a   = AD_W'(prod_r);
        add_b   = AD_W'(sum_r);
        add_sub = 1'b1;
      end
      S_SS: begin
        add_b   = AD_W'(prod_r);
        add_sub = 1'b1;
      end
      S_WL: begin
        add_a = acc_r;
        add_b = AD_W'(prod_r);
      end
      S_WH: begin
        add_a = acc_r;
        add_b = AD_W'(prod_r) <<< SUM_W;
      end
      S_CMP: begin
        add_a   = acc_r;
        add_b   = AD_W'(spread_r);
        add_sub = 1'b1;
      end
      S_RT: begin
        add_a   = acc_r;
        add_b   = root_r | aux_r;
        add_sub = 1'b1;
      end
      S_SAT: begin
        add_a   = AD_W'(num_abs) << FRAC_BITS;
        add_b   = root_r << (Z_W - 1);
        add_sub = 1'b1;
      end
      S_DV: begin
        add_a   = acc_r;
        add_b   = aux_r;
        add_sub = 1'b1;
      end
      default: begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
      end
    endcase
  end

  assign add_res = add_sub ? (add_a - add_b) : (add_a + add_b);
  assign add_ge  = !add_res[AD_W-1];

  // Last quotient bit folded in on the final divide step
  assign q_fin = {q_r[Z_W-3:0], add_ge};
  assign q_ext = {1'b0, q_fin};

  // Sequencer, series state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wl_r        <= WL_RESET;
      spread_r    <= '0;
      wr_slot_r   <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      sq_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Output register drains independently; the hand-off step reloads it itself
      if (out_fire && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            x_r       <= in_ch.sample;
            w_r       <= w_eff;
            full_r    <= full;
            ok_r      <= full || (fill_inc == w_eff);
            fill_r    <= full ? fill_base : fill_inc;
            wr_slot_r <= wr_slot_inc;
            if (clr) begin
              sum_r <= '0;
              sq_r  <= '0;
            end
            state_r <= S_MX;
          end
        end
        S_MX: begin
          sum_r   <= add_res[SUM_W-1:0];
          state_r <= S_MO;
        end
        S_MO: begin
          sq_r    <= add_res[SQ_W-1:0];
          state_r <= S_SO;
        end
        S_SO: begin
          sq_r    <= add_res[SQ_W-1:0];
          state_r <= S_SU;
        end
        S_SU: begin
          sum_r   <= add_res[SUM_W-1:0];
          state_r <= S_NM;
        end
        S_NM: begin
          num_r <= add_res[NUM_W-1:0];
          if (ok_r) begin
            state_r <= S_SS;
          end else begin
            res_z_r  <= '0;
            res_st_r <= ST_FILL;
            state_r  <= S_DONE;
          end
        end
        S_SS: begin
          acc_r   <= add_res;
          state_r <= S_WL;
        end
        S_WL: begin
          acc_r   <= add_res;
          state_r <= S_WH;
        end
        S_WH: begin
          acc_r   <= add_res;
          state_r <= S_CMP;
        end
        S_CMP: begin
          // Flat when D - min_spread <= 0 (covers a negative D too)
          if (!add_ge || add_res == '0) begin
            res_z_r  <= '0;
            res_st_r <= ST_FLAT;
            state_r  <= S_DONE;
          end else begin
            root_r  <= '0;
            aux_r   <= AD_W'(1) << (2 * ROOT_ITER - 2);
            cnt_r   <= CNT_W'(ROOT_ITER);
            state_r <= S_RT;
          end
        end
        S_RT: begin
          // One bit pair of the floor root per cycle; acc_r holds the remainder
          if (add_ge) begin
            acc_r  <= add_res;
            root_r <= (root_r >> 1) | aux_r;
          end else begin
            root_r <= root_r >> 1;
          end
          aux_r <= aux_r >> 2;
          cnt_r <= cnt_r - CNT_W'(1);
          if (cnt_r == CNT_W'(1)) begin
            state_r <= S_SAT;
          end
        end
        S_SAT: begin
          // |num| << F >= root << (Z_W-1) means the quotient overflows
          if (add_ge) begin
            res_z_r  <= num_neg ? Z_MIN : Z_MAX;
            res_st_r <= ST_OK;
            state_r  <= S_DONE;
          end else begin
            acc_r   <= AD_W'(num_abs) << FRAC_BITS;
            aux_r   <= root_r << (Z_W - 2);
            q_r     <= '0;
            cnt_r   <= CNT_W'(Z_W - 1);
            state_r <= S_DV;
          end
        end
        S_DV: begin
          // Restoring divide, one quotient bit per cycle
          if (add_ge) begin
            acc_r <= add_res;
          end
          q_r   <= q_fin;
          aux_r <= aux_r >> 1;
          cnt_r <= cnt_r - CNT_W'(1);
          if (cnt_r == CNT_W'(1)) begin
            res_z_r  <= num_neg ? (Z_W'(0) - q_ext) : q_ext;
            res_st_r <= ST_OK;
            state_r  <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_z_r     <= res_z_r;
            out_st_r    <= res_st_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase

      // Register writes; a window change starts a new series
      if (cfg_fire) begin
        unique case (cfg_ch.index)
          CFG_WINDOW: begin
            wl_r   <= cfg_ch.data[WL_W-1:0];
            fill_r <= '0;
            sum_r  <= '0;
            sq_r   <= '0;
          end
          CFG_SPREAD: begin
            spread_r <= cfg_ch.data[SPREAD_W-1:0];
          end
          default: begin
            spread_r <= spread_r;
          end
        endcase
      end
    end
  end

endmodule

[rtl/rzs_checker.sv]
// Port-level checker for the rolling z-score streamer, bound to the top level.
// Depends on rzs_pkg and rolling_zscore_streamer_top_defines.svh.
`include "rolling_zscore_streamer_top_defines.svh"

module rzs_checker import rzs_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic signed [Z_W-1:0] out_z_score,
  input logic [ST_W-1:0]       out_status
);

  // A stalled result stays offered
  `RZS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // A stalled result keeps its payload
  `RZS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_z_score) && $stable(out_status), "result changed while stalled")

  // Filling and flat results carry a zero score
  `RZS_ASSERT_NOW(a_zero_unless_ok, out_valid && out_status != ST_OK, out_z_score == '0, "nonzero score with non-ok status")

  // The sequencer is busy right after a sample transfer
  `RZS_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready, "ready right after a sample transfer")

endmodule

bind rolling_zscore_streamer_top rzs_checker u_rzs_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_z_score (out_ch.z_score),
  .out_status  (out_ch.status)
);

[bench/rolling_zscore_streamer_top_tb.sv]
// Self-checking bench for the rolling z-score streamer: runs of random samples and directed
// corner samples under several window and spread settings, with stalls on both sides.
// Depends on rzs_pkg and the rzs_in_if / rzs_out_if / rzs_cfg_if channel interfaces.
module rolling_zscore_streamer_top_tb;
  import rzs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_WIN     = 256;
  localparam int Z_FRAC      = 10;
  localparam int SAMPLE_MAX  = 2 ** (SAMPLE_BITS - 1) - 1;
  localparam int SAMPLE_MIN  = -SAMPLE_MAX - 1;
  localparam int FULL_SPAN   = -1;
  localparam int LONG_HOLD   = 400;
  localparam int DRAIN_WAIT  = 80;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          restart;
  } sample_item_t;

  typedef struct packed {
    logic signed [Z_W-1:0] z;
    logic [ST_W-1:0]       status;
  } zscore_t;

  logic clk = 1'b0;
  logic rst_n;

  rzs_cfg_if cfg_ch ();
  rzs_in_if  in_ch ();
  rzs_out_if out_ch ();

  rolling_zscore_streamer_top #(
    .MAX_WINDOW(MAX_WIN),
    .FRAC_BITS (Z_FRAC)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_ch(cfg_ch),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stimulus and scoreboard state
  sample_item_t pending_samples[$];
  zscore_t      expected_scores[$];
  int           in_offered = 0;
  int           in_taken = 0;
  int           mismatches = 0;
  int           cycles = 0;
  bit           idle_on = 1'b1;
  bit           hold_request = 1'b0;

  // Predictor copy of the block's registers and series state
  logic [WL_W-1:0]     win_len = WL_RESET;
  logic [SPREAD_W-1:0] spread_floor = '0;
  longint              hist[MAX_WIN];
  int                  slot = 0;
  longint              filled = 0;
  longint              run_sum = 0;
  longint              run_sq = 0;

  function automatic void restart_series();
    filled  = 0;
    run_sum = 0;
    run_sq  = 0;
  endfunction

  // Largest r with r*r <= v, built one bit at a time from the top
  function automatic longint floor_sqrt(input longint v);
    longint r;
    longint trial;
    int     b;
    r = 0;
    for (b = 31; b >= 0; b--) begin
      trial = r | (64'sd1 <<< b);
      if (trial * trial <= v) r = trial;
    end
    return r;
  endfunction

  // Advance the series by one sample and work out its z-score and status
  function automatic zscore_t predict_zscore(input sample_item_t item);
    longint  w;
    longint  x;
    longint  oldest;
    longint  wq;
    longint  ss;
    longint  root;
    longint  q;
    zscore_t res;
    w = (win_len == 0) ? 1 : (win_len > MAX_WIN) ? MAX_WIN : longint'(win_len);
    x = longint'($signed(item.value));
    res.z = '0;
    if (item.restart) restart_series();
    if (filled > w) restart_series();
    // full window: the oldest sample drops out
    if (filled == w) begin
      oldest  = hist[(slot + MAX_WIN - int'(w)) % MAX_WIN];
      run_sum -= oldest;
      run_sq  -= oldest * oldest;
    end else begin
      filled++;
    end
    run_sum += x;
    run_sq  += x * x;
    hist[slot] = x;
    slot = (slot + 1) % MAX_WIN;
    if (filled < w) begin
      res.status = ST_FILL;
    end else begin
      wq = w * run_sq;
      ss = run_sum * run_sum;
      if (wq < ss || (wq - ss) <= longint'(spread_floor)) begin
        res.status = ST_FLAT;
      end else begin
        root = floor_sqrt(wq - ss);
        if (root < 1) root = 1;
        q = ((w * x - run_sum) * (64'sd1 <<< Z_FRAC)) / root;
        if (q > longint'(Z_MAX)) q = longint'(Z_MAX);
        if (q < longint'(Z_MIN)) q = longint'(Z_MIN);
        res.z      = q[Z_W-1:0];
        res.status = ST_OK;
      end
    end
    return res;
  endfunction

  function automatic void flag_mismatch(input string field, input longint want,
                                        input longint got);
    mismatches++;
    $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endfunction

  // Sample source: one transfer at a time, random gaps between items
  int src_gap = 0;
  always @(negedge clk) begin : feed
    bit           next_valid;
    sample_item_t item;
    next_valid = in_ch.valid;
    if (next_valid && in_taken == in_offered) begin
      next_valid = 1'b0;
      if (idle_on && $urandom_range(0, 3) == 0) src_gap = $urandom_range(1, 16);
    end
    if (!next_valid && rst_n) begin
      if (src_gap > 0) begin
        src_gap--;
      end else if (pending_samples.size() > 0) begin
        item = pending_samples.pop_front();
        in_ch.sample     <= item.value;
        in_ch.new_series <= item.restart;
        next_valid = 1'b1;
        in_offered++;
      end
    end
    in_ch.valid <= next_valid;
  end

  // Result sink: random stall bursts, plus one long hold-off on request
  int  sink_stall = 0;
  int  hold_left = 0;
  bit  hold_started = 1'b0;
  always @(negedge clk) begin
    if (hold_request && !hold_started) begin
      hold_started = 1'b1;
      hold_left    = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (sink_stall > 0) begin
      sink_stall--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (idle_on && $urandom_range(0, 7) == 0) sink_stall = $urandom_range(1, 16);
    end
  end

  // Monitor: check result transfers, predict on sample transfers
  always @(posedge clk) begin : observe
    zscore_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_scores.size() == 0) begin
          mismatches++;
          $display("%0t ns: result with nothing expected, actual z_score %0d status %0d",
                   $time, out_ch.z_score, out_ch.status);
        end else begin
          want = expected_scores.pop_front();
          if (out_ch.z_score !== want.z)
            flag_mismatch("z_score", $signed(want.z), $signed(out_ch.z_score));
          if (out_ch.status !== want.status)
            flag_mismatch("status", want.status, out_ch.status);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_scores.push_back(predict_zscore({in_ch.sample, in_ch.new_series}));
        in_taken <= in_taken + 1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic push_item(input int value, input bit restart);
    sample_item_t it;
    it.value   = value[SAMPLE_BITS-1:0];
    it.restart = restart;
    pending_samples.push_back(it);
  endtask

  // Runs of samples around a random level; span picks flat, narrow, wide or full range
  task automatic queue_runs(input int total, input int min_len, input int max_len,
                            input int noise);
    int left;
    int len;
    int span;
    int center;
    int v;
    bit restart;
    left = total;
    while (left > 0) begin
      len = $urandom_range(min_len, max_len);
      if (len > left) len = left;
      case ($urandom_range(0, 3))
        0:       span = 0;
        1:       span = 4;
        2:       span = 300;
        default: span = FULL_SPAN;
      endcase
      center = SAMPLE_MIN + int'($urandom_range(0, 65535));
      for (int i = 0; i < len; i++) begin
        if (span == FULL_SPAN) v = SAMPLE_MIN + int'($urandom_range(0, 65535));
        else v = center + int'($urandom_range(0, 2 * span)) - span;
        if (v > SAMPLE_MAX) v = SAMPLE_MAX;
        if (v < SAMPLE_MIN) v = SAMPLE_MIN;
        restart = (i == 0 && $urandom_range(0, 1) == 1) ||
                  (noise > 0 && $urandom_range(1, noise) == 1);
        push_item(v, restart);
      end
      left -= len;
    end
  endtask

  // Register write over the config channel; predictor follows at the transfer
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_WINDOW: begin
        win_len = val[WL_W-1:0];
        restart_series();
      end
      CFG_SPREAD: spread_floor = val[SPREAD_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Block until every queued sample is in and every result is back
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_samples.size() != 0 || in_taken != in_offered ||
           expected_scores.size() != 0);
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] word;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.sample     = '0;
    in_ch.new_series = 1'b0;
    out_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = CFG_WINDOW;
    cfg_ch.data      = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: window 16, no spread threshold
    queue_runs(40, 10, 30, 40);
    wait_drained();

    // Window of zero acts as one: every window is flat
    write_reg(CFG_WINDOW, '0);
    push_item(SAMPLE_MAX, 1'b1);
    push_item(SAMPLE_MIN, 1'b0);
    wait_drained();

    // Two-sample window: unit z either way, equal pair is flat, restart refills
    write_reg(CFG_WINDOW, 2);
    push_item(SAMPLE_MIN, 1'b0);
    push_item(SAMPLE_MAX, 1'b0);
    push_item(SAMPLE_MAX, 1'b0);
    push_item(0, 1'b1);
    push_item(-1, 1'b0);
    wait_drained();

    // Highest threshold: everything that fills is flat
    write_reg(CFG_SPREAD, {SPREAD_W{1'b1}});
    write_reg(CFG_WINDOW, 4);
    push_item(100, 1'b0);
    push_item(-100, 1'b0);
    push_item(SAMPLE_MAX, 1'b0);
    push_item(SAMPLE_MIN, 1'b0);
    push_item(7, 1'b0);
    wait_drained();

    // Window of three, restart in the middle of a series
    write_reg(CFG_SPREAD, '0);
    write_reg(CFG_WINDOW, 3);
    push_item(1, 1'b0);
    push_item(2, 1'b0);
    push_item(3, 1'b0);
    push_item(1000, 1'b0);
    push_item(0, 1'b0);
    push_item(-5, 1'b1);
    push_item(-5, 1'b0);
    push_item(-5, 1'b0);
    push_item(9, 1'b0);
    wait_drained();

    // Largest window, written as 256 and then above range with junk upper bits
    write_reg(CFG_WINDOW, MAX_WIN);
    word = {16'($urandom), 32'($urandom)};
    word[WL_W-1:0] = {WL_W{1'b1}};
    write_reg(CFG_WINDOW, word);
    repeat (262) push_item(SAMPLE_MIN + int'($urandom_range(0, 65535)), 1'b0);
    wait_drained();

    // Small window against a moderate spread threshold
    write_reg(CFG_WINDOW, 5);
    write_reg(CFG_SPREAD, 48'($urandom_range(0, 2000)));
    queue_runs(40, 6, 20, 30);
    wait_drained();

    // Random window; sink holds off while samples keep coming
    write_reg(CFG_SPREAD, '0);
    write_reg(CFG_WINDOW, 9'($urandom_range(2, 40)));
    hold_request = 1'b1;
    queue_runs(40, 10, 50, 0);
    wait_drained();

    // Final stretch at full rate, no idle cycles on either side
    idle_on = 1'b0;
    write_reg(CFG_WINDOW, 8);
    write_reg(CFG_SPREAD, 48'($urandom_range(0, 100)));
    queue_runs(30, 8, 20, 25);
    wait_drained();

    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && expected_scores.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
